FILE: sv/sorted_list_insert_remove_assert.svh
// Assertion macros for the sorted list block.
`ifndef SORTED_LIST_INSERT_REMOVE_ASSERT_SVH
`define SORTED_LIST_INSERT_REMOVE_ASSERT_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define SLIR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Antecedent in one cycle implies the consequent in the next.
`define SLIR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SLIR_ASSERT(label, clk, rst, prop, msg)
`define SLIR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

FILE: sv/slir_pkg.sv
// Shared types and constants for the sorted list block.
package slir_pkg;

  localparam int DATA_W       = 32;
  localparam int COUNT_W      = 5;
  localparam int CAPACITY_DEF = 16;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef logic signed [DATA_W-1:0] data_t;

  // Command broadcast to every cell in the row.
  typedef struct packed {
    logic ins;  // insert, store not full
    logic rem;  // remove, matching entry present
  } cmd_t;

endpackage

FILE: sv/sorted_list_insert_remove.sv
// Latency: a result is valid the cycle after its request is accepted.
// Throughput: one request per cycle; every cell compares and shifts in the same cycle.
// A result held by a stalled sink blocks new requests until it is taken.
// Reset clears the entry count and the output valid; cell contents are left unset.
`include "sorted_list_insert_remove_assert.svh"
module sorted_list_insert_remove
  import slir_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [4:0]         count
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic          acc;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic [1:0]    status_next;
  logic          full;
  logic          empty;
  logic          found;
  cmd_t          cmd;

  data_t           entries [CAPACITY];
  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] eq_vec;
  logic [CW+COUNT_W-1:0] cnt_wide;

  assign in_ready = !out_valid || out_ready;
  assign acc      = in_valid && in_ready;
  assign full     = (cnt == CW'(CAPACITY));
  assign empty    = (cnt == '0);
  assign found    = |eq_vec;

  assign cmd.ins = acc && (func == FUNC_INSERT) && !full;
  assign cmd.rem = acc && (func == FUNC_REMOVE) && found;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    data_t prev_e;
    data_t next_e;
    logic  ltp;
    if (i == 0) begin : g_first
      assign prev_e = value;
      assign ltp    = 1'b1;
    end else begin : g_mid
      assign prev_e = entries[i-1];
      assign ltp    = lt_vec[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_e = entries[i];
    end else begin : g_inner
      assign next_e = entries[i+1];
    end
    slir_cell u_cell (
      .clk        (clk),
      .value      (value),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .lt_prev    (ltp),
      .occ        (IDX < cnt),
      .cmd        (cmd),
      .entry      (entries[i]),
      .lt         (lt_vec[i]),
      .eq         (eq_vec[i])
    );
  end

  always_comb begin
    cnt_next = cnt;
    if (cmd.ins) begin
      cnt_next = cnt + CW'(1);
    end else if (cmd.rem) begin
      cnt_next = cnt - CW'(1);
    end
  end

  always_comb begin
    priority if (func == FUNC_INSERT && full) begin
      status_next = ST_FULL;
    end else if (func == FUNC_REMOVE && empty) begin
      status_next = ST_EMPTY;
    end else if (func == FUNC_REMOVE && !found) begin
      status_next = ST_NOTFOUND;
    end else begin
      status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (acc) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      status <= status_next;
    end
  end

  // Reported count is the one after this request has taken effect.
  assign cnt_wide = {{COUNT_W{1'b0}}, cnt_next};

  always_ff @(posedge clk) begin
    if (acc) begin
      count <= cnt_wide[COUNT_W-1:0];
    end
  end

  `SLIR_ASSERT(a_cnt_bound, clk, rst, cnt <= CW'(CAPACITY), "entry count above capacity")
  `SLIR_ASSERT_NEXT(a_full_flag, clk, rst, acc && func == FUNC_INSERT && full,
                    status == ST_FULL && cnt == $past(cnt), "insert into full store not flagged")
  `SLIR_ASSERT_NEXT(a_ins_grow, clk, rst, acc && func == FUNC_INSERT && !full,
                    cnt == $past(cnt) + CW'(1) && status == ST_OK, "insert did not grow store")
  `SLIR_ASSERT_NEXT(a_rem_empty, clk, rst, acc && func == FUNC_REMOVE && empty,
                    status == ST_EMPTY && cnt == '0, "remove from empty store not flagged")
  `SLIR_ASSERT(a_shift_excl, clk, rst, !(cmd.ins && cmd.rem), "insert and remove at once")

endmodule

FILE: sv/slir_cell.sv
// One storage cell of the sorted row: compare against the request value and shift.
module slir_cell
  import slir_pkg::*;
(
  input  logic  clk,
  input  data_t value,
  input  data_t prev_entry,
  input  data_t next_entry,
  input  logic  lt_prev,
  input  logic  occ,
  input  cmd_t  cmd,
  output data_t entry,
  output logic  lt,
  output logic  eq
);

  data_t entry_next;

  assign lt = occ && (entry < value);
  assign eq = occ && (entry == value);

  // Entries below the value stay put; the rest move up on insert, down on remove.
  always_comb begin
    entry_next = entry;
    if (cmd.ins && !lt) begin
      entry_next = lt_prev ? value : prev_entry;
    end else if (cmd.rem && !lt) begin
      entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

FILE: test/tb.sv
// Self-checking testbench for the sorted list insert/remove block.
`timescale 1ns / 1ps
module tb;
  import slir_pkg::*;

  localparam int CAPACITY = 16;
  localparam int NUM_RANDOM = 1500;
  localparam int QUIET_TAIL = 150;
  localparam int DRAIN_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int NUM_DIRECTED = 24;

  typedef struct packed {
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
  } status_count_t;

  typedef struct {
    logic               f;
    data_t              v;
    bit                 fixed;
    logic [1:0]         st;
    logic [COUNT_W-1:0] cnt;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               func = FUNC_INSERT;
  data_t              value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic [COUNT_W-1:0] count;

  data_t         shadow_list[$];
  status_count_t awaited_status[$];
  dir_row_t      directed_rows[NUM_DIRECTED];
  bit            quiet = 1'b0;
  int            mismatches = 0;
  int            n_insert = 0;
  int            n_remove = 0;
  int            n_ok = 0;
  int            n_empty = 0;
  int            n_notfound = 0;
  int            n_full = 0;
  int            peak_count = 0;

  sorted_list_insert_remove #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .value    (value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .count    (count)
  );

  always #2 clk = ~clk;

  // Shadow of the store: an ascending queue; duplicates go ahead of equal entries.
  function automatic status_count_t update_shadow_list(logic f, data_t v);
    status_count_t r;
    int pos;
    pos = 0;
    r.status = ST_OK;
    if (f == FUNC_INSERT) begin
      if (shadow_list.size() >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        while (pos < shadow_list.size() && shadow_list[pos] < v) pos++;
        shadow_list.insert(pos, v);
      end
    end else if (shadow_list.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      while (pos < shadow_list.size() && shadow_list[pos] != v) pos++;
      if (pos == shadow_list.size()) r.status = ST_NOTFOUND;
      else shadow_list.delete(pos);
    end
    r.count = COUNT_W'(shadow_list.size());
    return r;
  endfunction

  // Small values and stored values make duplicates and remove hits common.
  function automatic data_t pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return data_t'($urandom_range(0, 16)) - 8;
    if (sel == 3) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7FFF_FFFF;
        2: return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    if (sel < 7 && shadow_list.size() != 0)
      return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
    return data_t'($urandom);
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic send_request(logic f, data_t v, bit fixed, status_count_t fixed_res);
    status_count_t pred;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    value <= v;
    do @(posedge clk); while (!in_ready);
    pred = update_shadow_list(f, v);
    awaited_status.push_back(fixed ? fixed_res : pred);
    if (f == FUNC_INSERT) n_insert++;
    else n_remove++;
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (awaited_status.size() != 0) @(posedge clk);
  endtask

  // Sink side: random stall bursts until the quiet tail.
  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    status_count_t exp_res;
    if (!rst && out_valid && out_ready) begin
      case (status)
        ST_OK:       n_ok++;
        ST_EMPTY:    n_empty++;
        ST_NOTFOUND: n_notfound++;
        default:     n_full++;
      endcase
      if (count > peak_count) peak_count = count;
      if (awaited_status.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d count=%0d", status, count));
      end else begin
        exp_res = awaited_status.pop_front();
        if (status !== exp_res.status)
          report_mismatch($sformatf("status got %0d exp %0d", status, exp_res.status));
        if (count !== exp_res.count)
          report_mismatch($sformatf("count got %0d exp %0d", count, exp_res.count));
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    status_count_t fixed_res;
    int bias;
    logic f;
    directed_rows = '{
      '{FUNC_REMOVE, 32'sd0,          1'b1, ST_EMPTY,    5'd0},  // remove from empty
      '{FUNC_INSERT, 32'sh7FFF_FFFF,  1'b1, ST_OK,       5'd1},
      '{FUNC_INSERT, 32'sh8000_0000,  1'b1, ST_OK,       5'd2},
      '{FUNC_REMOVE, 32'sd5,          1'b1, ST_NOTFOUND, 5'd2},  // absent value
      '{FUNC_INSERT, 32'sd0,          1'b0, ST_OK,       5'd0},
      '{FUNC_INSERT, -32'sd1,         1'b0, ST_OK,       5'd0},
      '{FUNC_INSERT, 32'sd0,          1'b0, ST_OK,       5'd0},  // duplicate
      '{FUNC_REMOVE, 32'sd0,          1'b0, ST_OK,       5'd0},
      '{FUNC_INSERT, 32'sd100,        1'b0, ST_OK,       5'd0},
      '{FUNC_INSERT, -32'sd100,       1'b0, ST_OK,       5'd0},
      '{FUNC_INSERT, 32'sd7,          1'b0, ST_OK,       5'd0},
      '{FUNC_INSERT, 32'sd7,          1'b0, ST_OK,       5'd0},
      '{FUNC_INSERT, 32'sd7,          1'b0, ST_OK,       5'd0},
      '{FUNC_INSERT, 32'sh5555_5555,  1'b0, ST_OK,       5'd0},
      '{FUNC_INSERT, 32'shAAAA_AAAA,  1'b0, ST_OK,       5'd0},
      '{FUNC_INSERT, 32'sd2,          1'b0, ST_OK,       5'd0},
      '{FUNC_INSERT, -32'sd2,         1'b0, ST_OK,       5'd0},
      '{FUNC_INSERT, 32'sd1000,       1'b0, ST_OK,       5'd0},
      '{FUNC_INSERT, -32'sd1000,      1'b0, ST_OK,       5'd0},
      '{FUNC_INSERT, 32'sd3,          1'b0, ST_OK,       5'd0},  // store now full
      '{FUNC_INSERT, 32'sd1,          1'b1, ST_FULL,     5'd16},
      '{FUNC_REMOVE, 32'sh8000_0000,  1'b1, ST_OK,       5'd15},
      '{FUNC_REMOVE, 32'sh7FFF_FFFF,  1'b1, ST_OK,       5'd14},
      '{FUNC_REMOVE, 32'sd7,          1'b0, ST_OK,       5'd0}
    };
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      fixed_res.status = directed_rows[i].st;
      fixed_res.count = directed_rows[i].cnt;
      send_request(directed_rows[i].f, directed_rows[i].v, directed_rows[i].fixed, fixed_res);
    end
    hold_until_drained();

    // Insert bias changes every segment so the store swings between empty and full.
    bias = 50;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 48 == 0) bias = 25 * $urandom_range(1, 3);
      if (n == NUM_RANDOM / 2) hold_until_drained();
      if (n == NUM_RANDOM - QUIET_TAIL) quiet = 1'b1;
      f = ($urandom_range(0, 99) < bias) ? FUNC_INSERT : FUNC_REMOVE;
      send_request(f, pick_value(), 1'b0, '0);
    end
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d inserts, %0d removes, peak count %0d",
             n_insert + n_remove, n_insert, n_remove, peak_count);
    $display("status seen: ok %0d, empty %0d, not found %0d, full %0d",
             n_ok, n_empty, n_notfound, n_full);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
